// ===== src/smes_pkg.sv =====
// Shared types, constants and codes of the sparse matrix entry store.
package smes_pkg;

  localparam int MAX_ROWS    = 256;
  localparam int MAX_COLS    = 256;
  localparam int CAPACITY    = 256;
  localparam int VALUE_WIDTH = 32;

  localparam int IDX_W     = $clog2(CAPACITY);
  localparam int CNT_W     = $clog2(CAPACITY + 1);
  localparam int SUM_W     = 40;
  localparam int CFG_W     = 9;
  localparam int CFG_IDX_W = 2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_NUM_ROWS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_COLS = 2'd1;

  // request types
  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_READ  = 1'b1;

  // status codes
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_RANGE = 2'd1;
  localparam logic [1:0] STAT_FULL  = 2'd2;

  typedef struct packed {
    logic               req_type;
    logic [7:0]         row;
    logic [7:0]         col;
    logic signed [31:0] value;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] read_value;
    logic               found;
    logic [8:0]         nonzero_count;
    logic signed [39:0] total_sum;
  } rsp_t;

  // one word of the entry memory
  typedef struct packed {
    logic [7:0]                    row;
    logic [7:0]                    col;
    logic signed [VALUE_WIDTH-1:0] value;
  } entry_t;

  // outcome of one scan over the entry memory
  typedef struct packed {
    logic                          done;
    logic                          hit;
    logic [IDX_W-1:0]              hit_idx;
    logic signed [VALUE_WIDTH-1:0] hit_value;
    logic                          free_ok;
    logic [IDX_W-1:0]              free_idx;
  } scan_rsp_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_t;

endpackage

// ===== src/smes_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module smes_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/smes_scan.sv =====
// Scan engine: walks the entry memory once, finds the matching entry and the lowest free slot.
module smes_scan (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       go,
  input  logic [7:0]                 key_row,
  input  logic [7:0]                 key_col,
  output logic                       ram_re,
  output logic [smes_pkg::IDX_W-1:0] ram_raddr,
  input  smes_pkg::entry_t           ram_rdata,
  input  logic                       slot_valid,
  output smes_pkg::scan_rsp_t        scan
);

  import smes_pkg::*;

  localparam logic [IDX_W-1:0] LAST = IDX_W'(CAPACITY - 1);

  logic                          scan_live;
  logic [IDX_W-1:0]              scan_idx;
  logic                          chk_live;
  logic [IDX_W-1:0]              chk_idx;
  logic                          chk_valid;
  logic                          hit;
  logic [IDX_W-1:0]              hit_idx;
  logic signed [VALUE_WIDTH-1:0] hit_value;
  logic                          free_ok;
  logic [IDX_W-1:0]              free_idx;
  logic                          done;
  logic                          match;

  assign ram_re    = scan_live;
  assign ram_raddr = scan_idx;
  assign match     = chk_valid && (ram_rdata.row == key_row) && (ram_rdata.col == key_col);

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_live <= 1'b0;
      chk_live  <= 1'b0;
      hit       <= 1'b0;
      free_ok   <= 1'b0;
      done      <= 1'b0;
    end else begin
      done <= 1'b0;
      if (go) begin
        scan_live <= 1'b1;
        chk_live  <= 1'b0;
        hit       <= 1'b0;
        free_ok   <= 1'b0;
      end else begin
        chk_live <= scan_live;
        if (scan_live && scan_idx == LAST) begin
          scan_live <= 1'b0;
        end
        if (chk_live) begin
          if (match && !hit) begin
            hit <= 1'b1;
          end
          if (!chk_valid && !free_ok) begin
            free_ok <= 1'b1;
          end
          if (chk_idx == LAST) begin
            done <= 1'b1;
          end
        end
      end
    end
  end

  // datapath, no reset needed
  always_ff @(posedge clk) begin
    if (go) begin
      scan_idx <= '0;
    end else if (scan_live && scan_idx != LAST) begin
      scan_idx <= scan_idx + IDX_W'(1);
    end
    chk_idx   <= scan_idx;
    chk_valid <= slot_valid;
    if (!go && chk_live) begin
      if (match && !hit) begin
        hit_idx   <= chk_idx;
        hit_value <= ram_rdata.value;
      end
      if (!chk_valid && !free_ok) begin
        free_idx <= chk_idx;
      end
    end
  end

  always_comb begin
    scan.done      = done;
    scan.hit       = hit;
    scan.hit_idx   = hit_idx;
    scan.hit_value = hit_value;
    scan.free_ok   = free_ok;
    scan.free_idx  = free_idx;
  end

endmodule

// ===== src/sparse_matrix_entry_store.sv =====
// Top level of the sparse matrix entry store: control, counters, valid bits and write-back.
//
//  channel   ports                         handshake
//  -------   ----------------------------  -----------------------------------
//  request   start, busy, request          taken at an edge with start & !busy
//  result    done, result                  one-cycle strobe, cannot be held off
//  config    cfg_we, cfg_index, cfg_data   written at an edge with cfg_we high
//
// Every in-range request scans the whole entry memory, one entry per cycle through the
// single RAM read port, before the result strobe is shown. An out-of-range request skips
// the scan: the state goes from S_IDLE straight to S_DONE, and the done register then
// shows its strobe.
// busy drops in the cycle the result strobe is shown, so the next request can be
// taken there. Reset clears the valid bits, count and running total at once; no
// clearing pass is needed. The receiver has no stall; results are never held.
module sparse_matrix_entry_store (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  smes_pkg::req_t                 request,
  output logic                           done,
  output smes_pkg::rsp_t                 result,
  input  logic                           cfg_we,
  input  logic [smes_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [smes_pkg::CFG_W-1:0]     cfg_data
);

  import smes_pkg::*;

  state_t state, state_next;

  req_t             req;          // latched request
  logic             oor;          // latched out-of-range flag
  logic [CFG_W-1:0] num_rows;
  logic [CFG_W-1:0] num_cols;
  logic [CAPACITY-1:0] valid;
  logic [CNT_W-1:0] count, count_next;
  logic signed [SUM_W-1:0] total, total_next;

  logic      accept;
  logic      in_oor;
  logic      go;

  // entry memory ports
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  entry_t           ram_wdata;
  logic             ram_re;
  logic [IDX_W-1:0] ram_raddr;
  entry_t           ram_rdata;
  logic             slot_valid;

  scan_rsp_t scan;

  logic                valid_set;
  logic                valid_clr;
  logic [IDX_W-1:0]    valid_idx;
  rsp_t                rsp_next;

  logic signed [VALUE_WIDTH-1:0] val_st;   // value as stored: wrapped to VALUE_WIDTH
  logic signed [SUM_W-1:0]       val_ext;
  logic signed [SUM_W-1:0]       old_ext;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  // a position is rejected against both the register and the build-time size
  assign in_oor = ({1'b0, request.row} >= num_rows) || (32'(request.row) >= MAX_ROWS)
               || ({1'b0, request.col} >= num_cols) || (32'(request.col) >= MAX_COLS);
  assign go     = accept && !in_oor;

  assign val_st  = VALUE_WIDTH'(req.value);
  assign val_ext = SUM_W'(val_st);
  assign old_ext = SUM_W'(scan.hit_value);

  assign slot_valid = valid[ram_raddr];

  smes_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (CAPACITY)
  ) u_entry_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  smes_scan u_scan (
    .clk        (clk),
    .rst        (rst),
    .go         (go),
    .key_row    (req.row),
    .key_col    (req.col),
    .ram_re     (ram_re),
    .ram_raddr  (ram_raddr),
    .ram_rdata  (ram_rdata),
    .slot_valid (slot_valid),
    .scan       (scan)
  );

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state, write-back and result forming
  always_comb begin
    state_next = state;
    ram_we     = 1'b0;
    ram_waddr  = scan.hit_idx;
    ram_wdata.row   = req.row;
    ram_wdata.col   = req.col;
    ram_wdata.value = val_st;
    valid_set  = 1'b0;
    valid_clr  = 1'b0;
    valid_idx  = scan.hit_idx;
    count_next = count;
    total_next = total;
    rsp_next.status     = STAT_OK;
    rsp_next.read_value = '0;
    rsp_next.found      = 1'b0;

    case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = in_oor ? S_DONE : S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan.done) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        state_next = S_IDLE;
        if (oor) begin
          rsp_next.status = STAT_RANGE;
        end else begin
          rsp_next.found = scan.hit;
          if (req.req_type == REQ_READ) begin
            if (scan.hit) begin
              rsp_next.read_value = 32'(scan.hit_value);
            end
          end else if (val_st == '0) begin
            // remove, if present
            if (scan.hit) begin
              valid_clr  = 1'b1;
              count_next = count - CNT_W'(1);
              total_next = total - old_ext;
            end
          end else if (scan.hit) begin
            // update in place
            ram_we     = 1'b1;
            total_next = total - old_ext + val_ext;
          end else if (!scan.free_ok) begin
            rsp_next.status = STAT_FULL;
          end else begin
            // insert at the lowest free slot
            ram_we     = 1'b1;
            ram_waddr  = scan.free_idx;
            valid_set  = 1'b1;
            valid_idx  = scan.free_idx;
            count_next = count + CNT_W'(1);
            total_next = total + val_ext;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    rsp_next.nonzero_count = 9'(count_next);
    rsp_next.total_sum     = total_next;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      num_rows <= CFG_W'(256);
      num_cols <= CFG_W'(256);
      valid    <= '0;
      count    <= '0;
      total    <= '0;
      done     <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_NUM_ROWS: num_rows <= cfg_data;
          REG_NUM_COLS: num_cols <= cfg_data;
          default: ;
        endcase
      end
      if (valid_set) begin
        valid[valid_idx] <= 1'b1;
      end else if (valid_clr) begin
        valid[valid_idx] <= 1'b0;
      end
      count <= count_next;
      total <= total_next;
      done  <= (state == S_DONE);
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      req <= request;
      oor <= in_oor;
    end
    if (state == S_DONE) begin
      result <= rsp_next;
    end
  end

endmodule
